@@ rtl/core/scs1_pkg.sv @@
// ----------------------------------------------------------------------------
// scs1_pkg
// Shared types, key codes and the character ROM for the set 1 scan decoder.
// ----------------------------------------------------------------------------
package scs1_pkg;

  localparam int unsigned CODE_W = 8;
  localparam int unsigned KEY_W  = 7;
  localparam int unsigned CHAR_W = 7;

  localparam logic [CODE_W-1:0] CODE_E0 = 8'hE0;
  localparam logic [CODE_W-1:0] CODE_E1 = 8'hE1;

  localparam logic [KEY_W-1:0] KC_LSHIFT = 7'h2A;
  localparam logic [KEY_W-1:0] KC_RSHIFT = 7'h36;
  localparam logic [KEY_W-1:0] KC_CTRL   = 7'h1D;
  localparam logic [KEY_W-1:0] KC_ALT    = 7'h38;
  localparam logic [KEY_W-1:0] KC_CAPS   = 7'h3A;

  typedef enum logic [2:0] {
    PFX_NONE = 3'b001,
    PFX_E0   = 3'b010,
    PFX_E1   = 3'b100
  } pfx_t;

  typedef struct packed {
    pfx_t pfx;
    logic lshift;
    logic rshift;
    logic caps;
    logic lctrl;
    logic rctrl;
    logic lalt;
    logic ralt;
  } scs1_st_t;

  typedef struct packed {
    logic              emit;
    logic [CHAR_W-1:0] ch;
    logic              ctrl;
    logic              alt;
  } dec_res_t;

  // plain / shifted ASCII per key, 0 where unmapped
  function automatic logic [CHAR_W-1:0] rom_lookup(input logic [KEY_W-1:0] key,
                                                   input logic shifted);
    logic [CHAR_W-1:0] ch;
    ch = '0;
    case (key)
      7'h02: ch = shifted ? 7'h21 : 7'h31;
      7'h03: ch = shifted ? 7'h40 : 7'h32;
      7'h04: ch = shifted ? 7'h23 : 7'h33;
      7'h05: ch = shifted ? 7'h24 : 7'h34;
      7'h06: ch = shifted ? 7'h25 : 7'h35;
      7'h07: ch = shifted ? 7'h5E : 7'h36;
      7'h08: ch = shifted ? 7'h26 : 7'h37;
      7'h09: ch = shifted ? 7'h2A : 7'h38;
      7'h0A: ch = shifted ? 7'h28 : 7'h39;
      7'h0B: ch = shifted ? 7'h29 : 7'h30;
      7'h0C: ch = shifted ? 7'h5F : 7'h2D;
      7'h0D: ch = shifted ? 7'h2B : 7'h3D;
      7'h0E: ch = 7'h7F;
      7'h0F: ch = 7'h09;
      7'h10: ch = shifted ? 7'h51 : 7'h71;
      7'h11: ch = shifted ? 7'h57 : 7'h77;
      7'h12: ch = shifted ? 7'h45 : 7'h65;
      7'h13: ch = shifted ? 7'h52 : 7'h72;
      7'h14: ch = shifted ? 7'h54 : 7'h74;
      7'h15: ch = shifted ? 7'h59 : 7'h79;
      7'h16: ch = shifted ? 7'h55 : 7'h75;
      7'h17: ch = shifted ? 7'h49 : 7'h69;
      7'h18: ch = shifted ? 7'h4F : 7'h6F;
      7'h19: ch = shifted ? 7'h50 : 7'h70;
      7'h1A: ch = shifted ? 7'h7B : 7'h5B;
      7'h1B: ch = shifted ? 7'h7D : 7'h5D;
      7'h1C: ch = 7'h0A;
      7'h1E: ch = shifted ? 7'h41 : 7'h61;
      7'h1F: ch = shifted ? 7'h53 : 7'h73;
      7'h20: ch = shifted ? 7'h44 : 7'h64;
      7'h21: ch = shifted ? 7'h46 : 7'h66;
      7'h22: ch = shifted ? 7'h47 : 7'h67;
      7'h23: ch = shifted ? 7'h48 : 7'h68;
      7'h24: ch = shifted ? 7'h4A : 7'h6A;
      7'h25: ch = shifted ? 7'h4B : 7'h6B;
      7'h26: ch = shifted ? 7'h4C : 7'h6C;
      7'h27: ch = shifted ? 7'h3A : 7'h3B;
      7'h28: ch = shifted ? 7'h22 : 7'h27;
      7'h29: ch = shifted ? 7'h7E : 7'h60;
      7'h2B: ch = shifted ? 7'h7C : 7'h5C;
      7'h2C: ch = shifted ? 7'h5A : 7'h7A;
      7'h2D: ch = shifted ? 7'h58 : 7'h78;
      7'h2E: ch = shifted ? 7'h43 : 7'h63;
      7'h2F: ch = shifted ? 7'h56 : 7'h76;
      7'h30: ch = shifted ? 7'h42 : 7'h62;
      7'h31: ch = shifted ? 7'h4E : 7'h6E;
      7'h32: ch = shifted ? 7'h4D : 7'h6D;
      7'h33: ch = shifted ? 7'h3C : 7'h2C;
      7'h34: ch = shifted ? 7'h3E : 7'h2E;
      7'h35: ch = shifted ? 7'h3F : 7'h2F;
      7'h39: ch = 7'h20;
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/core/scan_code_set1_to_ascii.sv @@
// ----------------------------------------------------------------------------
// scan_code_set1_to_ascii
// Set 1 scan code byte stream in, ASCII characters with modifier flags out.
// ----------------------------------------------------------------------------
//  channel | dir | word contents
//  in_     | in  | tdata[7:0] scan_code
//  out_    | out | tdata[6:0] char_code; tuser[0] ctrl_held, tuser[1] alt_held
//
//  One byte per cycle unless the output stalls; path: input register, decode,
//  result register. Prefix, modifier, break and prefixed bytes produce no word.
//  Synchronous active-low reset clears prefix, modifier, caps and valid state.
//  A stalled result register holds the decoder; the input register then fills
//  and in_tready drops.
// ----------------------------------------------------------------------------
module scan_code_set1_to_ascii (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] scan_code
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] char_code, [7] zero
  output logic [1:0] out_tuser   // [0] ctrl_held, [1] alt_held
);

  logic                        in_vld_r;
  logic [scs1_pkg::CODE_W-1:0] code_r;
  scs1_pkg::scs1_st_t          st_r;
  scs1_pkg::scs1_st_t          st_nxt;
  scs1_pkg::dec_res_t          res;
  logic                        out_free;
  logic                        adv;

  assign adv       = in_vld_r & out_free;
  assign in_tready = ~in_vld_r | out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      code_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{pfx: scs1_pkg::PFX_NONE, default: 1'b0};
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  scs1_dec u_dec (
    .code   (code_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  scs1_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (adv & res.emit),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_e0_arms: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (code_r == scs1_pkg::CODE_E0) |=> st_r.pfx == scs1_pkg::PFX_E0)
    else $error("E0 byte did not arm prefix");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.emit |=> out_tvalid)
    else $error("decoded character lost");

  a_rose_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(adv))
    else $error("result appeared without a decode");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_vld_r && out_tvalid && !out_tready)
    else $error("input stalled with no downstream stall");

endmodule

@@ rtl/core/scs1_dec.sv @@
// ----------------------------------------------------------------------------
// scs1_dec
// Combinational decode of one scan byte: prefix, modifier flags, character.
// ----------------------------------------------------------------------------
module scs1_dec (
  input  logic [scs1_pkg::CODE_W-1:0] code,
  input  scs1_pkg::scs1_st_t          st,
  output scs1_pkg::scs1_st_t          st_nxt,
  output scs1_pkg::dec_res_t          res
);

  logic [scs1_pkg::KEY_W-1:0]  key;
  logic                        make;
  logic [scs1_pkg::CHAR_W-1:0] raw_ch;
  logic                        is_upper;
  logic                        is_lower;

  assign key  = code[scs1_pkg::KEY_W-1:0];
  assign make = ~code[scs1_pkg::CODE_W-1];

  assign raw_ch   = scs1_pkg::rom_lookup(key, st.lshift | st.rshift);
  assign is_upper = (raw_ch >= 7'h41) && (raw_ch <= 7'h5A);
  assign is_lower = (raw_ch >= 7'h61) && (raw_ch <= 7'h7A);

  always_comb begin
    st_nxt   = st;
    res.emit = 1'b0;
    if (code == scs1_pkg::CODE_E0) begin
      st_nxt.pfx = scs1_pkg::PFX_E0;
    end else if (code == scs1_pkg::CODE_E1) begin
      st_nxt.pfx = scs1_pkg::PFX_E1;
    end else begin
      st_nxt.pfx = scs1_pkg::PFX_NONE;
      unique case (st.pfx)
        scs1_pkg::PFX_E0: begin
          // extended: only right ctrl / right alt matter
          if (key == scs1_pkg::KC_CTRL) begin
            st_nxt.rctrl = make;
          end else if (key == scs1_pkg::KC_ALT) begin
            st_nxt.ralt = make;
          end
        end
        scs1_pkg::PFX_E1: begin
          // pause sequence byte, dropped
        end
        default: begin
          unique case (key)
            scs1_pkg::KC_RSHIFT: st_nxt.rshift = make;
            scs1_pkg::KC_LSHIFT: st_nxt.lshift = make;
            scs1_pkg::KC_ALT:    st_nxt.lalt   = make;
            scs1_pkg::KC_CTRL:   st_nxt.lctrl  = make;
            scs1_pkg::KC_CAPS: begin
              if (make) begin
                st_nxt.caps = ~st.caps;
              end
            end
            default: res.emit = make;
          endcase
        end
      endcase
    end
    // caps lock flips letter case only
    res.ch   = (st.caps && (is_upper || is_lower)) ? (raw_ch ^ 7'h20) : raw_ch;
    res.ctrl = st_nxt.lctrl | st_nxt.rctrl;
    res.alt  = st_nxt.lalt | st_nxt.ralt;
  end

endmodule

@@ rtl/core/scs1_out_reg.sv @@
// ----------------------------------------------------------------------------
// scs1_out_reg
// Result register: holds one decoded word until the sink takes it.
// ----------------------------------------------------------------------------
module scs1_out_reg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  scs1_pkg::dec_res_t          res,
  output logic                        free,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [6:0] char_code, [7] zero
  output logic [1:0]                  out_tuser   // [0] ctrl_held, [1] alt_held
);

  logic                        vld_r;
  logic [scs1_pkg::CHAR_W-1:0] ch_r;
  logic                        ctrl_r;
  logic                        alt_r;

  assign free = ~vld_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (free) begin
      vld_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (free && push) begin
      ch_r   <= res.ch;
      ctrl_r <= res.ctrl;
      alt_r  <= res.alt;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {1'b0, ch_r};
  assign out_tuser  = {alt_r, ctrl_r};

endmodule
